>>> rtl/piu_pkg.sv
// Shared types and constants for the palette index unpacker.
// No dependencies; RTL files use this package by scoped names, the testbench imports it.
`default_nettype none

package piu_pkg;

  localparam int PALETTE_DEPTH_DEF = 256;
  localparam int LANES_DEF         = 8;
  localparam int MAX_LANES         = 8;

  localparam int WORD_W      = 32;
  localparam int HALF_W      = 16;
  localparam int INDEX_W     = 8;
  localparam int GROUP_W     = 40;
  localparam int COUNT_W     = 4;
  localparam int IBITS_W     = 4;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  // group layout per mode: one above the top bit of the first index
  localparam int TOP5 = 40;
  localparam int TOP6 = 24;
  localparam int TOP8 = 32;
  localparam int NARROW_COUNT = 4;

  localparam logic [IBITS_W-1:0] IBITS_RESET = 4'd8;
  localparam logic [IBITS_W-1:0] IBITS_FIVE  = 4'd5;
  localparam logic [IBITS_W-1:0] IBITS_SIX   = 4'd6;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_INDEX_BITS = 2'd0,
    REG_ELEM_FP32  = 2'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MODE_IDX5 = 3'b001,
    MODE_IDX6 = 3'b010,
    MODE_IDX8 = 3'b100
  } idx_mode_t;

  typedef struct packed {
    logic [INDEX_W-1:0] idx;
    logic               active;
  } lane_sel_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctrl_t;

  // anything but 5 or 6 falls back to byte indices
  function automatic idx_mode_t decode_mode(logic [IBITS_W-1:0] ib);
    idx_mode_t m;
    case (ib)
      IBITS_FIVE: m = MODE_IDX5;
      IBITS_SIX:  m = MODE_IDX6;
      default:    m = MODE_IDX8;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

>>> rtl/piu_if.sv
// Channel interfaces of the palette index unpacker: item in, result out, config writes.
// Depends on piu_pkg for field widths.
`default_nettype none

interface piu_item_if;
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [piu_pkg::INDEX_W-1:0]  entry_index;
  logic [piu_pkg::WORD_W-1:0]   entry_value;
  logic [piu_pkg::GROUP_W-1:0]  packed_group;

  modport source (output valid, func, entry_index, entry_value, packed_group, input ready);
  modport sink   (input valid, func, entry_index, entry_value, packed_group, output ready);
endinterface

interface piu_result_if;
  logic                         valid;
  logic                         ready;
  logic [piu_pkg::WORD_W-1:0]   value0;
  logic [piu_pkg::WORD_W-1:0]   value1;
  logic [piu_pkg::WORD_W-1:0]   value2;
  logic [piu_pkg::WORD_W-1:0]   value3;
  logic [piu_pkg::WORD_W-1:0]   value4;
  logic [piu_pkg::WORD_W-1:0]   value5;
  logic [piu_pkg::WORD_W-1:0]   value6;
  logic [piu_pkg::WORD_W-1:0]   value7;
  logic [piu_pkg::COUNT_W-1:0]  value_count;

  modport source (output valid, value0, value1, value2, value3, value4, value5, value6,
                  value7, value_count, input ready);
  modport sink   (input valid, value0, value1, value2, value3, value4, value5, value6,
                  value7, value_count, output ready);
endinterface

interface piu_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [piu_pkg::CFG_INDEX_W-1:0] index;
  logic [piu_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/piu_unpack.sv
// Splits a packed group into per-lane palette indices and the value count.
// Depends on piu_pkg.
`default_nettype none

module piu_unpack #(
  parameter int LANES = piu_pkg::LANES_DEF
) (
  input  wire logic [piu_pkg::GROUP_W-1:0] group,
  input  wire logic [piu_pkg::IBITS_W-1:0] index_bits,
  output piu_pkg::lane_sel_t               sel [LANES],
  output logic [piu_pkg::COUNT_W-1:0]      count
);

  piu_pkg::idx_mode_t mode;

  assign mode  = piu_pkg::decode_mode(index_bits);
  assign count = (mode == piu_pkg::MODE_IDX5) ? piu_pkg::COUNT_W'(LANES)
                                               : piu_pkg::COUNT_W'(piu_pkg::NARROW_COUNT);

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    localparam int B5 = piu_pkg::TOP5 - 1 - 5 * i;
    if (i < piu_pkg::NARROW_COUNT) begin : g_wide
      localparam int B6 = piu_pkg::TOP6 - 1 - 6 * i;
      localparam int B8 = piu_pkg::TOP8 - 1 - 8 * i;
      always_comb begin
        sel[i].idx    = '0;
        sel[i].active = 1'b1;
        case (mode)
          piu_pkg::MODE_IDX5: sel[i].idx = piu_pkg::INDEX_W'(group[B5 -: 5]);
          piu_pkg::MODE_IDX6: sel[i].idx = piu_pkg::INDEX_W'(group[B6 -: 6]);
          piu_pkg::MODE_IDX8: sel[i].idx = group[B8 -: 8];
          default:            sel[i].active = 1'b0;
        endcase
      end
    end else begin : g_narrow
      // upper lanes only carry indices in 5-bit mode
      always_comb begin
        sel[i].idx    = piu_pkg::INDEX_W'(group[B5 -: 5]);
        sel[i].active = (mode == piu_pkg::MODE_IDX5);
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/piu_lane.sv
// One lookup lane: a private copy of the palette, one read per cycle, registered data.
// Depends on piu_pkg.
`default_nettype none

module piu_lane #(
  parameter int PALETTE_DEPTH = piu_pkg::PALETTE_DEPTH_DEF,
  localparam int AW = $clog2(PALETTE_DEPTH)
) (
  input  wire logic                         clk,
  input  wire piu_pkg::mem_ctrl_t           ctrl,
  input  wire logic [AW-1:0]                wr_addr,
  input  wire logic [piu_pkg::WORD_W-1:0]   wr_data,
  input  wire piu_pkg::lane_sel_t           sel,
  input  wire logic                         fp32,
  output logic [piu_pkg::WORD_W-1:0]        word
);

  logic [piu_pkg::WORD_W-1:0] mem [PALETTE_DEPTH];
  logic [piu_pkg::WORD_W-1:0] rd_data;
  logic                       keep;
  logic                       in_range;

  assign in_range = {1'b0, sel.idx} < (piu_pkg::INDEX_W + 1)'(PALETTE_DEPTH);

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_data <= mem[sel.idx[AW-1:0]];
      keep    <= sel.active && in_range;
    end
  end

  always_comb begin
    word = '0;
    if (keep) begin
      word = fp32 ? rd_data
                  : {{(piu_pkg::WORD_W - piu_pkg::HALF_W){1'b0}}, rd_data[piu_pkg::HALF_W-1:0]};
    end
  end

endmodule

`default_nettype wire

>>> rtl/piu_merge.sv
// Output stage: gathers the lane words and count into one registered result word.
// Depends on piu_pkg.
`default_nettype none

module piu_merge #(
  parameter int LANES = piu_pkg::LANES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [piu_pkg::COUNT_W-1:0]  in_count,
  input  wire logic [piu_pkg::WORD_W-1:0]   lane_word [LANES],
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [piu_pkg::WORD_W-1:0]        values [piu_pkg::MAX_LANES],
  output logic [piu_pkg::COUNT_W-1:0]       out_count
);

  logic load;

  assign in_ready = !out_valid || out_ready;
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_count <= in_count;
    end
  end

  for (genvar i = 0; i < piu_pkg::MAX_LANES; i++) begin : g_val
    if (i < LANES) begin : g_used
      always_ff @(posedge clk) begin
        if (load) begin
          values[i] <= lane_word[i];
        end
      end
    end else begin : g_unused
      assign values[i] = '0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/palette_index_unpacker_unit.sv
// Top level of the palette index unpacker: config registers, lane array, output stage.
// Depends on piu_pkg, piu_if, piu_unpack, piu_lane, piu_merge.
//
//  port    dir   handshake      payload
//  item    in    valid/ready    func, entry_index, entry_value, packed_group
//  result  out   valid/ready    value0..value7, value_count
//  cfg     in    valid/ready    index, data (ready held high)
//
// One item per cycle unless result stalls; decode words pass the read and output registers.
// Each lane owns a palette copy with one read port, so all indices are looked up in parallel;
// a load item writes every copy in its cycle if its index is in range, and gives no result.
// Stalls on result hold the output register, then the read stage, then item.ready drops.
// Synchronous reset clears control and fp32, sets index_bits to 8; palette stays undefined.
`default_nettype none

module palette_index_unpacker_unit #(
  parameter int PALETTE_DEPTH = piu_pkg::PALETTE_DEPTH_DEF,
  parameter int LANES         = piu_pkg::LANES_DEF
) (
  input wire logic       clk,
  input wire logic       rst,
  piu_item_if.sink       item,
  piu_result_if.source   result,
  piu_cfg_if.sink        cfg
);

  localparam int AW = $clog2(PALETTE_DEPTH);

  logic [piu_pkg::IBITS_W-1:0] index_bits;
  logic                        element_is_fp32;

  logic                        s1_valid;
  logic [piu_pkg::COUNT_W-1:0] s1_count;
  logic                        s1_fp32;
  logic                        merge_ready;
  logic                        accept;

  piu_pkg::lane_sel_t          sel [LANES];
  logic [piu_pkg::COUNT_W-1:0] count;
  piu_pkg::mem_ctrl_t          ctrl;
  logic [piu_pkg::WORD_W-1:0]  lane_word [LANES];
  logic [piu_pkg::WORD_W-1:0]  values [piu_pkg::MAX_LANES];

  // config port
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      index_bits      <= piu_pkg::IBITS_RESET;
      element_is_fp32 <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        piu_pkg::REG_INDEX_BITS: index_bits      <= cfg.data[piu_pkg::IBITS_W-1:0];
        piu_pkg::REG_ELEM_FP32:  element_is_fp32 <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // read stage control
  assign item.ready = !s1_valid || merge_ready;
  assign accept     = item.valid && item.ready;

  assign ctrl.rd_en = accept && item.func;
  assign ctrl.wr_en = accept && !item.func &&
                      ({1'b0, item.entry_index} < (piu_pkg::INDEX_W + 1)'(PALETTE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= accept && item.func;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      s1_count <= count;
      s1_fp32  <= element_is_fp32;
    end
  end

  piu_unpack #(.LANES(LANES)) u_unpack (
    .group      (item.packed_group),
    .index_bits (index_bits),
    .sel        (sel),
    .count      (count)
  );

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    piu_lane #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_lane (
      .clk     (clk),
      .ctrl    (ctrl),
      .wr_addr (item.entry_index[AW-1:0]),
      .wr_data (item.entry_value),
      .sel     (sel[i]),
      .fp32    (s1_fp32),
      .word    (lane_word[i])
    );
  end

  piu_merge #(.LANES(LANES)) u_merge (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (merge_ready),
    .in_count  (s1_count),
    .lane_word (lane_word),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .values    (values),
    .out_count (result.value_count)
  );

  assign result.value0 = values[0];
  assign result.value1 = values[1];
  assign result.value2 = values[2];
  assign result.value3 = values[3];
  assign result.value4 = values[4];
  assign result.value5 = values[5];
  assign result.value6 = values[6];
  assign result.value7 = values[7];

endmodule

`default_nettype wire

>>> rtl/piu_checker.sv
// Port-level checks for palette_index_unpacker_unit, attached by bind.
// Depends on piu_pkg and the top level's interface ports.
`default_nettype none

module piu_checker #(
  parameter int LANES = piu_pkg::LANES_DEF
) (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        item_valid,
  input wire logic                        item_ready,
  input wire logic                        item_func,
  input wire logic                        result_valid,
  input wire logic                        result_ready,
  input wire logic [piu_pkg::WORD_W-1:0]  value0,
  input wire logic [piu_pkg::WORD_W-1:0]  value4,
  input wire logic [piu_pkg::WORD_W-1:0]  value5,
  input wire logic [piu_pkg::WORD_W-1:0]  value6,
  input wire logic [piu_pkg::WORD_W-1:0]  value7,
  input wire logic [piu_pkg::COUNT_W-1:0] value_count
);

  // count is either the narrow-mode four or the lane count
  a_count: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (value_count == piu_pkg::COUNT_W'(piu_pkg::NARROW_COUNT)) ||
                     (value_count == piu_pkg::COUNT_W'(LANES)))
    else $error("value_count out of set");

  // lanes past the count read zero
  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && value_count == piu_pkg::COUNT_W'(piu_pkg::NARROW_COUNT)) |->
      (value4 == '0 && value5 == '0 && value6 == '0 && value7 == '0))
    else $error("unused lane word not zero");

  // a fresh result comes from a decode word that passed the read stage and output register
  a_latency: assert property (@(posedge clk) disable iff (rst)
    ($rose(result_valid) && !$past(rst) && !$past(rst, 2)) |->
      $past(item_valid && item_ready && item_func, 2))
    else $error("result without matching decode word");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=>
      (result_valid && $stable(value0) && $stable(value_count)))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind palette_index_unpacker_unit piu_checker #(.LANES(LANES)) u_piu_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .item_func    (item.func),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .value0       (result.value0),
  .value4       (result.value4),
  .value5       (result.value5),
  .value6       (result.value6),
  .value7       (result.value7),
  .value_count  (result.value_count)
);

`default_nettype wire

>>> sim/palette_index_unpacker_unit_test.sv
// Self-checking test of palette_index_unpacker_unit: palette loads, decodes in every index mode.
// Depends on rtl/piu_pkg.sv, rtl/piu_if.sv and the unit's RTL.

module palette_index_unpacker_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import piu_pkg::*;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_DECODE = 1'b1;

  localparam int IDX5_W = 5;
  localparam int IDX6_W = 6;
  localparam int IDX8_W = 8;
  localparam int MAX_REPORTS = 10;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS = 100;

  typedef struct packed {
    logic               func;
    logic [INDEX_W-1:0] entry;
    logic [WORD_W-1:0]  word;
    logic [GROUP_W-1:0] grp;
  } palette_item_t;

  typedef struct packed {
    logic [MAX_LANES-1:0][WORD_W-1:0] val;
    logic [COUNT_W-1:0]               cnt;
  } lookup_word_t;

  logic clk;
  logic rst;

  piu_item_if   item_ch ();
  piu_result_if result_ch ();
  piu_cfg_if    cfg_ch ();

  palette_index_unpacker_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  // shadow of the palette and the config registers
  logic [WORD_W-1:0]  lut_copy [PALETTE_DEPTH_DEF];
  logic [IBITS_W-1:0] mode_bits;
  logic               wide_words;

  palette_item_t send_queue [$];
  lookup_word_t  lookup_queue [$];
  palette_item_t next_item;
  logic          item_taken;
  logic          quiet;
  int            errors;
  int            reports;

  always #5 clk = ~clk;

  function automatic lookup_word_t lut_decode(logic [GROUP_W-1:0] grp);
    lookup_word_t r;
    idx_mode_t    m;
    int           width;
    int           top;
    int           count;
    int           shift;
    logic [INDEX_W-1:0] idx;
    logic [WORD_W-1:0]  w;
    case (mode_bits)
      IBITS_FIVE: m = MODE_IDX5;
      IBITS_SIX:  m = MODE_IDX6;
      default:    m = MODE_IDX8;
    endcase
    case (m)
      MODE_IDX5: begin
        width = IDX5_W; top = TOP5; count = MAX_LANES;
      end
      MODE_IDX6: begin
        width = IDX6_W; top = TOP6; count = NARROW_COUNT;
      end
      default: begin
        width = IDX8_W; top = TOP8; count = NARROW_COUNT;
      end
    endcase
    if (count > LANES_DEF) count = LANES_DEF;
    r = '0;
    for (int ln = 0; ln < MAX_LANES; ln++) begin
      if (ln < count) begin
        shift = top - width * (ln + 1);
        idx = INDEX_W'((grp >> shift) & ((40'd1 << width) - 40'd1));
        w = lut_copy[idx];
        if (!wide_words) w[WORD_W-1:HALF_W] = '0;
        r.val[ln] = w;
      end
    end
    r.cnt = COUNT_W'(count);
    return r;
  endfunction

  // item driver
  always @(negedge clk) begin
    if (!item_ch.valid || item_taken) begin
      if (!rst && send_queue.size() != 0 && (quiet || $urandom_range(99) >= 6)) begin
        next_item = send_queue.pop_front();
        item_ch.valid        <= 1'b1;
        item_ch.func         <= next_item.func;
        item_ch.entry_index  <= next_item.entry;
        item_ch.entry_value  <= next_item.word;
        item_ch.packed_group <= next_item.grp;
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    result_ch.ready <= quiet || ($urandom_range(99) >= 6);
  end

  task automatic report_field(input string name, input logic [WORD_W-1:0] exp_v,
                              input logic [WORD_W-1:0] got_v);
    errors++;
    if (reports < MAX_REPORTS) begin
      reports++;
      $display("mismatch %s: expected %h got %h at %0t", name, exp_v, got_v, $realtime);
    end
  endtask

  // predictor and result checker
  always @(posedge clk) begin
    lookup_word_t exp_w;
    lookup_word_t got_w;
    item_taken <= item_ch.valid && item_ch.ready;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got_w.val = {result_ch.value7, result_ch.value6, result_ch.value5, result_ch.value4,
                   result_ch.value3, result_ch.value2, result_ch.value1, result_ch.value0};
      got_w.cnt = result_ch.value_count;
      if (lookup_queue.size() == 0) begin
        report_field("unexpected word, value0", '0, got_w.val[0]);
      end else begin
        exp_w = lookup_queue.pop_front();
        for (int ln = 0; ln < MAX_LANES; ln++) begin
          if (got_w.val[ln] !== exp_w.val[ln])
            report_field($sformatf("value%0d", ln), exp_w.val[ln], got_w.val[ln]);
        end
        if (got_w.cnt !== exp_w.cnt)
          report_field("value_count", WORD_W'(exp_w.cnt), WORD_W'(got_w.cnt));
      end
    end
    if (!rst && item_ch.valid && item_ch.ready) begin
      if (item_ch.func == FUNC_LOAD)
        lut_copy[item_ch.entry_index] = item_ch.entry_value;
      else
        lookup_queue.push_back(lut_decode(item_ch.packed_group));
    end
  end

  task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= r;
    cfg_ch.data  <= d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (r == REG_INDEX_BITS) mode_bits = d[IBITS_W-1:0];
    else wide_words = d[0];
  endtask

  // upper data bits are don't-care, so they carry noise
  task automatic set_mode(input logic [IBITS_W-1:0] ib, input logic fp);
    logic [CFG_DATA_W-1:0] d;
    d = $urandom();
    d[IBITS_W-1:0] = ib;
    write_reg(REG_INDEX_BITS, d);
    d = $urandom();
    d[0] = fp;
    write_reg(REG_ELEM_FP32, d);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic push_item(input logic func, input logic [INDEX_W-1:0] entry,
                           input logic [WORD_W-1:0] word, input logic [GROUP_W-1:0] grp);
    palette_item_t it;
    it.func  = func;
    it.entry = entry;
    it.word  = word;
    it.grp   = grp;
    send_queue.push_back(it);
  endtask

  task automatic push_decode(input logic [GROUP_W-1:0] grp);
    push_item(FUNC_DECODE, INDEX_W'($urandom()), $urandom(), grp);
  endtask

  // waits until the send queue and the pipe are empty; loads give no word, so it pads with the requested idle cycles
  task automatic drain(input int pad);
    @(posedge clk);
    while (send_queue.size() != 0 || item_ch.valid || lookup_queue.size() != 0)
      @(posedge clk);
    repeat (pad) @(posedge clk);
  endtask

  initial begin
    logic [IBITS_W-1:0] ib_list [10];
    logic               fp_list [10];
    logic [WORD_W-1:0]  word;
    logic               is_load;
    ib_list = '{4'd5, 4'd6, 4'd8, 4'd7, 4'd5, 4'd6, 4'd0, 4'd15, 4'd8, 4'd6};
    fp_list = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0};
    clk = 1'b0;
    rst = 1'b1;
    quiet = 1'b0;
    errors = 0;
    reports = 0;
    item_taken = 1'b0;
    mode_bits = IBITS_RESET;
    wide_words = 1'b0;
    item_ch.valid = 1'b0;
    item_ch.func = FUNC_LOAD;
    item_ch.entry_index = '0;
    item_ch.entry_value = '0;
    item_ch.packed_group = '0;
    result_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_INDEX_BITS;
    cfg_ch.data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill the whole palette so no lookup hits an unwritten entry
    for (int e = 0; e < PALETTE_DEPTH_DEF; e++) begin
      word = $urandom();
      if (e == 0) word = '0;
      if (e == PALETTE_DEPTH_DEF - 1) word = '1;
      push_item(FUNC_LOAD, INDEX_W'(e), word, {8'($urandom()), 32'($urandom())});
    end

    // directed: reset mode is byte indices, half words
    push_decode('0);
    push_decode('1);
    push_decode(40'hAB_0102_03FF);
    push_item(FUNC_LOAD, 8'd3, 32'h1234_ABCD, '1);
    push_decode(40'h00_0303_0303);  // reads the entry loaded by the item before
    drain(SETTLE_CYCLES);

    set_mode(IBITS_FIVE, 1'b1);
    push_decode('0);
    push_decode('1);
    push_decode(40'h55_5555_5555);
    push_decode(40'hAA_AAAA_AAAA);
    push_item(FUNC_LOAD, 8'd31, 32'hFFFF_0001, '0);
    push_decode('1);
    drain(SETTLE_CYCLES);

    set_mode(IBITS_SIX, 1'b0);
    push_decode('1);
    push_decode(40'hFF_FF00_0000);  // only bits above the group set
    push_decode(40'h00_0FC0_3F00);
    drain(SETTLE_CYCLES);

    set_mode(4'd7, 1'b1);
    push_decode('1);
    push_decode(40'h00_FF00_FF00);
    drain(SETTLE_CYCLES);

    set_mode(4'd0, 1'b0);
    push_decode(40'h12_3456_789A);
    drain(SETTLE_CYCLES);

    set_mode(4'd15, 1'b1);
    push_decode(40'hFE_DCBA_9876);
    drain(SETTLE_CYCLES);

    // random phases, one per mode setting, the last with a random index width
    for (int ph = 0; ph <= 10; ph++) begin
      if (ph < 10) set_mode(ib_list[ph], fp_list[ph]);
      else set_mode(IBITS_W'($urandom_range(15)), 1'($urandom_range(1)));
      quiet = (ph == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 5 && n == PHASE_ITEMS / 2) drain(0);
        is_load = ($urandom_range(99) < 20);
        push_item(is_load ? FUNC_LOAD : FUNC_DECODE,
                  $urandom_range(1) ? INDEX_W'($urandom_range(63)) : INDEX_W'($urandom()),
                  $urandom(), {8'($urandom()), 32'($urandom())});
      end
      drain(SETTLE_CYCLES);
    end
    quiet = 1'b0;

    drain(SETTLE_CYCLES);
    if (lookup_queue.size() != 0) errors++;
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

endmodule

>>> sim.f
rtl/piu_pkg.sv
rtl/piu_if.sv
rtl/piu_unpack.sv
rtl/piu_lane.sv
rtl/piu_merge.sv
rtl/palette_index_unpacker_unit.sv
rtl/piu_checker.sv
sim/palette_index_unpacker_unit_test.sv
